// ===== hdl/pwb_pkg.sv =====
// Shared types, constants and helpers for the palette window RGB565 blit unit.
package pwb_pkg;

    localparam int SCREEN_W_DEF = 320;
    localparam int SCREEN_H_DEF = 200;

    // Coordinate compare width: covers screen sizes up to 2047.
    localparam int CMP_W       = 11;
    localparam int X_W         = 9;
    localparam int Y_W         = 8;
    localparam int IDX_W       = 8;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 24;
    localparam int C565_W      = 16;
    localparam int PAL_DEPTH   = 256;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 40;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_PAL   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_EN     = 3'd4;

    localparam logic [C565_W-1:0] COLOR_BLACK = 16'h0000;

    typedef struct packed {
        logic [X_W-1:0] left;
        logic [Y_W-1:0] top;
        logic [X_W-1:0] width;
        logic [Y_W-1:0] height;
        logic           pad_en;
    } t_win_cfg;

    typedef struct packed {
        logic emit;
        logic in_win;
    } t_pix_ctl;

    function automatic logic [C565_W-1:0] pack565(input logic [RGB_W-1:0] rgb);
        return {rgb[23:19], rgb[15:10], rgb[7:3]};
    endfunction

endpackage

// ===== hdl/pwb_window.sv =====
// Window and screen clipping decision for one pixel.
module pwb_window #(
    parameter int SCREEN_W = pwb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = pwb_pkg::SCREEN_H_DEF
) (
    input  pwb_pkg::t_win_cfg          i_cfg,
    input  logic [pwb_pkg::X_W-1:0]    i_x,
    input  logic [pwb_pkg::Y_W-1:0]    i_y,
    output pwb_pkg::t_pix_ctl          o_ctl
);
    localparam int CW = pwb_pkg::CMP_W;
    localparam logic [CW-1:0] SW = CW'(SCREEN_W);
    localparam logic [CW-1:0] SH = CW'(SCREEN_H);

    logic [CW-1:0] x_ext, y_ext, left_ext, top_ext;
    logic [CW-1:0] x_sum, y_sum, x_end, y_end;
    logic          on_screen, win_nonempty, in_win;

    always_comb begin
        x_ext    = CW'(i_x);
        y_ext    = CW'(i_y);
        left_ext = CW'(i_cfg.left);
        top_ext  = CW'(i_cfg.top);
        x_sum    = left_ext + CW'(i_cfg.width);
        y_sum    = top_ext + CW'(i_cfg.height);
        x_end    = (x_sum > SW) ? SW : x_sum;
        y_end    = (y_sum > SH) ? SH : y_sum;
        on_screen    = (x_ext < SW) && (y_ext < SH);
        win_nonempty = (i_cfg.width != '0) && (i_cfg.height != '0);
        in_win = (x_ext >= left_ext) && (x_ext < x_end)
              && (y_ext >= top_ext) && (y_ext < y_end);
        o_ctl.in_win = in_win;
        o_ctl.emit   = win_nonempty && on_screen && (in_win || i_cfg.pad_en);
    end

endmodule

// ===== hdl/pwb_palette.sv =====
// Palette RAM: one write port, one registered read port.
module pwb_palette (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [pwb_pkg::IDX_W-1:0]     i_waddr,
    input  logic [pwb_pkg::RGB_W-1:0]     i_wdata,
    input  logic                          i_re,
    input  logic [pwb_pkg::IDX_W-1:0]     i_raddr,
    output logic [pwb_pkg::RGB_W-1:0]     o_rdata
);
    logic [pwb_pkg::RGB_W-1:0] r_mem [pwb_pkg::PAL_DEPTH];
    logic [pwb_pkg::RGB_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/palette_window_rgb565_blit_unit.sv =====
// Top level of the palette window RGB565 blit unit.
//
//  channel  dir  handshake                     content
//  s_axis   in   s_axis_tvalid/s_axis_tready   pixel or palette-write transfer
//  m_axis   out  m_axis_tvalid/m_axis_tready   RGB565 pixel with coordinate
//  cfg      in   i_cfg_we                      window and pad registers
//
// One transfer per cycle in while s_axis_tready is high; a pixel result is registered in
// stage 1 at its transfer, then moves into the output register, from which it leaves.
// Palette RAM read at input transfer, data registered, packed into the output register.
// A palette write is visible to a pixel in the very next cycle; no forwarding needed.
// Stalls on m_axis back up through one stage; s_axis_tready stays high while m_axis_tready
// is high. Synchronous active-low reset clears valid flags and sets the window to 0,0, default size, no pad.
module palette_window_rgb565_blit_unit #(
    parameter int SCREEN_W = pwb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = pwb_pkg::SCREEN_H_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pos_x[8:0], pos_y[16:9], pixel_index[24:17], entry_index[32:25],
    // entry_red[40:33], entry_green[48:41], entry_blue[56:49], zero[63:57]
    input  logic [pwb_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x[8:0], out_y[16:9], color565[32:17], zero[39:33]
    output logic [pwb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [pwb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int XW = pwb_pkg::X_W;
    localparam int YW = pwb_pkg::Y_W;
    localparam int SCREEN_W_RST = pwb_pkg::SCREEN_W_DEF;
    localparam int SCREEN_H_RST = pwb_pkg::SCREEN_H_DEF;

    pwb_pkg::t_win_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= '0;
            r_cfg.top    <= '0;
            r_cfg.width  <= XW'(SCREEN_W_RST);
            r_cfg.height <= YW'(SCREEN_H_RST);
            r_cfg.pad_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwb_pkg::REG_ROI_LEFT:   r_cfg.left   <= i_cfg_data[XW-1:0];
                pwb_pkg::REG_ROI_TOP:    r_cfg.top    <= i_cfg_data[YW-1:0];
                pwb_pkg::REG_ROI_WIDTH:  r_cfg.width  <= i_cfg_data[XW-1:0];
                pwb_pkg::REG_ROI_HEIGHT: r_cfg.height <= i_cfg_data[YW-1:0];
                pwb_pkg::REG_PAD_EN:     r_cfg.pad_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [XW-1:0]                  in_x;
    logic [YW-1:0]                  in_y;
    logic [pwb_pkg::IDX_W-1:0]      in_pix_idx, in_entry_idx;
    logic [pwb_pkg::RGB_W-1:0]      in_rgb;
    logic                           in_xfer, pix_xfer, pal_xfer;
    pwb_pkg::t_pix_ctl              ctl;
    logic [pwb_pkg::RGB_W-1:0]      pal_rdata;

    assign in_x         = s_axis_tdata[8:0];
    assign in_y         = s_axis_tdata[16:9];
    assign in_pix_idx   = s_axis_tdata[24:17];
    assign in_entry_idx = s_axis_tdata[32:25];
    assign in_rgb       = {s_axis_tdata[40:33], s_axis_tdata[48:41], s_axis_tdata[56:49]};

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign pix_xfer = in_xfer && (s_axis_tuser == pwb_pkg::OP_PIXEL);
    assign pal_xfer = in_xfer && (s_axis_tuser == pwb_pkg::OP_PAL);

    pwb_window #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_window (
        .i_cfg (r_cfg),
        .i_x   (in_x),
        .i_y   (in_y),
        .o_ctl (ctl)
    );

    pwb_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_xfer),
        .i_waddr (in_entry_idx),
        .i_wdata (in_rgb),
        .i_re    (pix_xfer),
        .i_raddr (in_pix_idx),
        .o_rdata (pal_rdata)
    );

    // Stage 1: waits on palette read data.
    logic          r_s1_valid, r_s1_inside;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;
    // Output register.
    logic                          r_out_valid;
    logic [XW-1:0]                 r_out_x;
    logic [YW-1:0]                 r_out_y;
    logic [pwb_pkg::C565_W-1:0]    r_out_color;
    logic                          s1_adv;

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= pix_xfer && ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_xfer) begin
            r_s1_x      <= in_x;
            r_s1_y      <= in_y;
            r_s1_inside <= ctl.in_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_color <= r_s1_inside ? pwb_pkg::pack565(pal_rdata) : pwb_pkg::COLOR_BLACK;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_color, r_out_y, r_out_x};

endmodule

// ===== hdl/pwb_checker.sv =====
// Port-level checker for the blit unit, bound to the top level.
module pwb_checker #(
    parameter int SCREEN_W = pwb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = pwb_pkg::SCREEN_H_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pwb_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    localparam int CW = pwb_pkg::CMP_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped or changed under stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled while output side can move");

    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CW'(m_axis_tdata[8:0]) < CW'(SCREEN_W))
                       && (CW'(m_axis_tdata[16:9]) < CW'(SCREEN_H)))
        else $error("output pixel off screen");

endmodule

bind palette_window_rgb565_blit_unit pwb_checker #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
) u_pwb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
